>>> sv/assert_macros.svh
// shared assertion macros for the dispersion cost block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge out of reset
`define SCDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true out of reset
`define SCDC_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> sv/scdc_pkg.sv
package scdc_pkg;

    // field widths of the stream words
    localparam int unsigned OP_W       = 3;
    localparam int unsigned NODE_IN_W  = 6;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned NCOUNT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned MIN_OUT_W  = 16;
    localparam int unsigned TIE_OUT_W  = 11;
    localparam int unsigned CAP_OUT_W  = 22;
    localparam int unsigned COST_OUT_W = 33;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 88;
    localparam int unsigned OUT_PAD_W  =
        OUT_DATA_W - MIN_OUT_W - TIE_OUT_W - CAP_OUT_W - COST_OUT_W;
    localparam int unsigned IN_PAD_W   = IN_DATA_W - 2 * NODE_IN_W - VALUE_W;

    // command queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [CFG_W-1:0]    REQ_RESET    = 16'd0;
    localparam logic [CFG_W-1:0]    CW_RESET     = 16'd10000;
    localparam logic [CFG_W-1:0]    DW_RESET     = 16'd11;
    localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd64;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WDIST = 3'd0,
        OP_WCAP  = 3'd1,
        OP_SEL   = 3'd2,
        OP_DESEL = 3'd3,
        OP_EVAL  = 3'd4
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQ    = 2'd0,
        CFG_CW     = 2'd1,
        CFG_DW     = 2'd2,
        CFG_NCOUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]    required_capacity;
        logic [CFG_W-1:0]    capacity_weight;
        logic [CFG_W-1:0]    distance_weight;
        logic [NCOUNT_W-1:0] node_count;
    } t_cfg;

endpackage

>>> sv/scdc_front.sv
module scdc_front import scdc_pkg::*; #(
    parameter int unsigned MAX_NODES = 64,
    parameter int unsigned NODE_W    = 6,
    parameter int unsigned CMD_W     = OP_W + 2 * NODE_W + VALUE_W
) (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [OP_W-1:0]      i_op,
    input  logic [NODE_IN_W-1:0] i_node_a,
    input  logic [NODE_IN_W-1:0] i_node_b,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic [NCOUNT_W-1:0]  i_node_count,
    input  logic                 i_blocked,
    input  logic                 i_full,
    output logic                 o_push,
    output logic [CMD_W-1:0]     o_cmd
);

    localparam int unsigned LIM_W = NODE_IN_W + NODE_W + 1;

    logic [LIM_W-1:0]            lim;
    logic                        a_lt_max;
    logic                        b_lt_max;
    logic                        a_in;
    logic                        b_in;
    logic [NODE_W+NODE_IN_W-1:0] a_ext;
    logic [NODE_W+NODE_IN_W-1:0] b_ext;
    logic [NODE_W-1:0]           a_n;
    logic [NODE_W-1:0]           b_n;
    logic [NODE_W-1:0]           lo_n;
    logic [NODE_W-1:0]           hi_n;
    logic [NODE_W-1:0]           first_n;
    logic [NODE_W-1:0]           second_n;
    logic                        keep;

    // range checks against the table size and the nodes in use
    assign lim      = LIM_W'(MAX_NODES);
    assign a_lt_max = LIM_W'(i_node_a) < lim;
    assign b_lt_max = LIM_W'(i_node_b) < lim;
    assign a_in     = a_lt_max && ({1'b0, i_node_a} < i_node_count);
    assign b_in     = b_lt_max && ({1'b0, i_node_b} < i_node_count);

    // node indexes at table width, pair ordered low to high
    assign a_ext = {{NODE_W{1'b0}}, i_node_a};
    assign b_ext = {{NODE_W{1'b0}}, i_node_b};
    assign a_n   = a_ext[NODE_W-1:0];
    assign b_n   = b_ext[NODE_W-1:0];
    assign lo_n  = (a_n < b_n) ? a_n : b_n;
    assign hi_n  = (a_n < b_n) ? b_n : a_n;

    // only a distance write reorders its nodes, the others keep node_a first
    assign first_n  = (i_op == OP_WDIST) ? lo_n : a_n;
    assign second_n = (i_op == OP_WDIST) ? hi_n : b_n;

    // drop words that leave the state unchanged
    always_comb begin
        case (i_op)
            OP_WDIST: keep = a_in && b_in && (i_node_a != i_node_b);
            OP_WCAP:  keep = a_in;
            OP_SEL:   keep = a_in;
            OP_DESEL: keep = a_lt_max;
            OP_EVAL:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign o_ready = !i_full && !i_blocked;
    assign o_push  = i_valid && o_ready && keep;
    assign o_cmd   = {i_op, first_n, second_n, i_value};

endmodule

>>> sv/scdc_fifo.sv
module scdc_fifo #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_empty = (r_count == '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/scdc_back.sv
`include "assert_macros.svh"

module scdc_back import scdc_pkg::*; #(
    parameter int unsigned MAX_NODES = 64,
    parameter int unsigned DIST_BITS = 16,
    parameter int unsigned NODE_W    = 6,
    parameter int unsigned CMD_W     = OP_W + 2 * NODE_W + VALUE_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_empty,
    input  logic [CMD_W-1:0]      i_cmd,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [MIN_OUT_W-1:0]  o_min,
    output logic [TIE_OUT_W-1:0]  o_ties,
    output logic [CAP_OUT_W-1:0]  o_cap,
    output logic [COST_OUT_W-1:0] o_cost
);

    localparam int unsigned AW         = 2 * NODE_W;
    localparam int unsigned DIST_DEPTH = 1 << AW;
    localparam int unsigned CAP_DEPTH  = 1 << NODE_W;
    localparam int unsigned CSUM_W     = VALUE_W + $clog2(MAX_NODES);
    localparam int unsigned PAIRS      = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int unsigned TIE_W      = $clog2(PAIRS + 1);
    localparam int unsigned PD_W       = DIST_BITS + CFG_W;
    localparam int unsigned PC_W       = 2 * CFG_W;
    localparam int unsigned CALC_W     = ((PD_W > PC_W) ? PD_W : PC_W) + 2;
    localparam logic [NODE_W-1:0] LAST_I = NODE_W'(MAX_NODES - 2);
    localparam logic [NODE_W-1:0] LAST_J = NODE_W'(MAX_NODES - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CAP   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // head command fields
    logic [OP_W-1:0]              c_op;
    logic [NODE_W-1:0]            c_a;
    logic [NODE_W-1:0]            c_b;
    logic [VALUE_W-1:0]           c_val;
    logic [DIST_BITS+VALUE_W-1:0] c_val_ext;
    logic [DIST_BITS-1:0]         c_dist;

    assign c_op      = i_cmd[CMD_W-1 -: OP_W];
    assign c_a       = i_cmd[2*NODE_W+VALUE_W-1 -: NODE_W];
    assign c_b       = i_cmd[NODE_W+VALUE_W-1 -: NODE_W];
    assign c_val     = i_cmd[VALUE_W-1:0];
    assign c_val_ext = {{DIST_BITS{1'b0}}, c_val};
    assign c_dist    = c_val_ext[DIST_BITS-1:0];

    // state and datapath registers
    logic [AW-1:0]          r_clr;
    logic [OP_W-1:0]        r_op;
    logic [NODE_W-1:0]      r_a;
    logic [VALUE_W-1:0]     r_val;
    logic [MAX_NODES-1:0]   r_mask;
    logic [CSUM_W-1:0]      r_sum;
    logic [NODE_W-1:0]      r_i;
    logic [NODE_W-1:0]      r_j;
    logic                   r_rd_vld;
    logic [DIST_BITS-1:0]   r_dist_q;
    logic [VALUE_W-1:0]     r_cap_q;
    logic [DIST_BITS-1:0]   r_min;
    logic [TIE_W-1:0]       r_ties;
    logic                   r_have;
    logic [PD_W-1:0]        r_pd;
    logic [PC_W-1:0]        r_pc;
    logic                   r_out_valid;
    logic [MIN_OUT_W-1:0]   r_res_min;
    logic [TIE_OUT_W-1:0]   r_res_ties;
    logic [CAP_OUT_W-1:0]   r_res_cap;
    logic [COST_OUT_W-1:0]  r_res_cost;

    // memories
    logic [DIST_BITS-1:0] dist_mem [DIST_DEPTH];
    logic [VALUE_W-1:0]   cap_mem  [CAP_DEPTH];

    logic                 dist_we;
    logic [AW-1:0]        dist_waddr;
    logic [DIST_BITS-1:0] dist_wdata;
    logic                 cap_we;
    logic [NODE_W-1:0]    cap_waddr;
    logic [VALUE_W-1:0]   cap_wdata;

    // scan control
    logic row_on;
    logic row_end;
    logic scan_last;
    logic rd_fire;
    logic out_free;

    assign row_on    = r_mask[r_i];
    assign row_end   = !row_on || (r_j == LAST_J);
    assign scan_last = (r_i == LAST_I) && row_end;
    assign rd_fire   = (r_state == S_SCAN) && row_on && r_mask[r_j];
    assign out_free  = !r_out_valid || i_res_ready;

    // shortfall and final cost terms
    logic [CSUM_W-1:0]          req_ext;
    logic [CSUM_W-1:0]          short_diff;
    logic [CFG_W-1:0]           shortfall;
    logic [CALC_W-1:0]          cost_full;
    logic [DIST_BITS+MIN_OUT_W-1:0] min_ext;
    logic [TIE_W+TIE_OUT_W-1:0]     ties_ext;
    logic [CSUM_W+CAP_OUT_W-1:0]    sum_ext;

    assign req_ext    = CSUM_W'(i_cfg.required_capacity);
    assign short_diff = req_ext - r_sum;
    assign shortfall  = (r_sum < req_ext) ? short_diff[CFG_W-1:0] : '0;
    assign cost_full  = CALC_W'(r_pd) - CALC_W'(r_pc) - CALC_W'(r_ties);
    assign min_ext    = {{MIN_OUT_W{1'b0}}, r_min};
    assign ties_ext   = {{TIE_OUT_W{1'b0}}, r_ties};
    assign sum_ext    = {{CAP_OUT_W{1'b0}}, r_sum};

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        dist_we    = 1'b0;
        dist_waddr = r_clr;
        dist_wdata = '0;
        cap_we     = 1'b0;
        cap_waddr  = r_clr[NODE_W-1:0];
        cap_wdata  = '0;
        case (r_state)
            S_CLEAR: begin
                dist_we = 1'b1;
                cap_we  = 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (c_op)
                        OP_WDIST: begin
                            dist_we    = 1'b1;
                            dist_waddr = {c_a, c_b};
                            dist_wdata = c_dist;
                        end
                        OP_WCAP, OP_SEL, OP_DESEL: n_state = S_CAP;
                        OP_EVAL:                   n_state = S_SCAN;
                        default:                   n_state = S_IDLE;
                    endcase
                end
            end
            S_CAP: begin
                if (r_op == OP_WCAP) begin
                    cap_we    = 1'b1;
                    cap_waddr = r_a;
                    cap_wdata = r_val;
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_clearing = (r_state == S_CLEAR);

    // distance memory, upper triangle at {low node, high node}
    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        r_dist_q <= dist_mem[{r_i, r_j}];
    end

    // capacity memory, read at the head node when it is popped
    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            cap_mem[cap_waddr] <= cap_wdata;
        end
        r_cap_q <= cap_mem[c_a];
    end

    // latched command, products and result fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op  <= c_op;
            r_a   <= c_a;
            r_val <= c_val;
        end
        if (r_state == S_MUL) begin
            r_pd <= PD_W'(r_min) * PD_W'(i_cfg.distance_weight);
            r_pc <= PC_W'(i_cfg.capacity_weight) * PC_W'(shortfall);
        end
        if ((r_state == S_OUT) && out_free) begin
            r_res_min  <= min_ext[MIN_OUT_W-1:0];
            r_res_ties <= ties_ext[TIE_OUT_W-1:0];
            r_res_cap  <= sum_ext[CAP_OUT_W-1:0];
            r_res_cost <= cost_full[COST_OUT_W-1:0];
        end
    end

    // control state, mask, sum and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_mask      <= '0;
            r_sum       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_rd_vld    <= 1'b0;
            r_min       <= '0;
            r_ties      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_fire;

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            // mask and running capacity sum
            if (r_state == S_CAP) begin
                case (r_op)
                    OP_WCAP: begin
                        if (r_mask[r_a]) begin
                            r_sum <= r_sum - CSUM_W'(r_cap_q) + CSUM_W'(r_val);
                        end
                    end
                    OP_SEL: begin
                        if (!r_mask[r_a]) begin
                            r_mask[r_a] <= 1'b1;
                            r_sum       <= r_sum + CSUM_W'(r_cap_q);
                        end
                    end
                    OP_DESEL: begin
                        if (r_mask[r_a]) begin
                            r_mask[r_a] <= 1'b0;
                            r_sum       <= r_sum - CSUM_W'(r_cap_q);
                        end
                    end
                    default: r_sum <= r_sum;
                endcase
            end

            // scan start and pair walk
            if (o_pop && (c_op == OP_EVAL)) begin
                r_i    <= '0;
                r_j    <= NODE_W'(1);
                r_min  <= '0;
                r_ties <= '0;
                r_have <= 1'b0;
            end else if (r_state == S_SCAN) begin
                if (row_end) begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_i + NODE_W'(2);
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end

            // minimum and tie tracking on returned distances
            if (r_rd_vld) begin
                if (!r_have || (r_dist_q < r_min)) begin
                    r_min  <= r_dist_q;
                    r_ties <= TIE_W'(1);
                    r_have <= 1'b1;
                end else if (r_dist_q == r_min) begin
                    r_ties <= r_ties + 1'b1;
                end
            end

            // output word register
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_min       = r_res_min;
    assign o_ties      = r_res_ties;
    assign o_cap       = r_res_cap;
    assign o_cost      = r_res_cost;

    // checks
    `SCDC_ASSERT(a_empty_mask_sum, i_clk, i_rst_n, (r_mask == '0) |-> (r_sum == '0), "sum nonzero with empty mask")
    `SCDC_ASSERT(a_have_ties, i_clk, i_rst_n, r_have == (r_ties != '0), "tie count out of step with minimum")
    `SCDC_NEVER(a_no_result_clear, i_clk, i_rst_n, (r_state == S_CLEAR) && r_out_valid, "result during clear")
    `SCDC_ASSERT(a_result_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_OUT), "result outside output step")

endmodule

>>> sv/subset_min_pair_distance_cost.sv
// subset_min_pair_distance_cost: cost of a selected node subset
// input stream (s_axis): tuser carries the operation, tdata the nodes and value;
//   writes load a distance or a capacity, select and deselect edit the subset,
//   evaluate returns one word on m_axis; other operations return nothing
// configuration channel (cfg): index 0 required capacity, 1 capacity weight,
//   2 distance weight, 3 node count; always ready, write only while idle
// back end: a distance write is done in the idle state as it is popped; a
//   capacity write, select or deselect also passes through the capacity step
//   (registered capacity memory read); an evaluate walks the upper triangle
//   of the distance memory, one read per cycle, skipping an unselected row
//   as a whole, then passes through the drain, multiply and output steps
// a four-word command queue lets the input keep accepting during a walk
// reset: the distance and capacity memories are swept to zero, one entry a
//   cycle, 4^log2(MAX_NODES) entries (4096 at 64 nodes); tready low meanwhile
// stall: the result sits in an output register; while it is not taken the
//   back end holds its next result and the queue fills before tready drops
module subset_min_pair_distance_cost import scdc_pkg::*; #(
    parameter int unsigned MAX_NODES = 64,
    parameter int unsigned DIST_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // node_a, node_b, value, pad
    input  logic [OP_W-1:0]       i_s_axis_tuser,  // op
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // min_distance, tie_count,
                                                   // selected_capacity, cost, pad
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int unsigned NODE_W = $clog2(MAX_NODES);
    localparam int unsigned CMD_W  = OP_W + 2 * NODE_W + VALUE_W;

    t_cfg r_cfg;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.required_capacity <= REQ_RESET;
            r_cfg.capacity_weight   <= CW_RESET;
            r_cfg.distance_weight   <= DW_RESET;
            r_cfg.node_count        <= NCOUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REQ:    r_cfg.required_capacity <= i_cfg_data;
                CFG_CW:     r_cfg.capacity_weight   <= i_cfg_data;
                CFG_DW:     r_cfg.distance_weight   <= i_cfg_data;
                CFG_NCOUNT: r_cfg.node_count        <= i_cfg_data[NCOUNT_W-1:0];
                default:    r_cfg                   <= r_cfg;
            endcase
        end
    end

    logic             push;
    logic [CMD_W-1:0] push_cmd;
    logic             pop;
    logic [CMD_W-1:0] head_cmd;
    logic             full;
    logic             empty;
    logic             clearing;

    // front: decode and filter input words
    scdc_front #(
        .MAX_NODES (MAX_NODES),
        .NODE_W    (NODE_W),
        .CMD_W     (CMD_W)
    ) u_front (
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_node_a     (i_s_axis_tdata[NODE_IN_W-1:0]),
        .i_node_b     (i_s_axis_tdata[2*NODE_IN_W-1:NODE_IN_W]),
        .i_value      (i_s_axis_tdata[2*NODE_IN_W+VALUE_W-1:2*NODE_IN_W]),
        .i_node_count (r_cfg.node_count),
        .i_blocked    (clearing),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // command queue
    scdc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    logic [MIN_OUT_W-1:0]  res_min;
    logic [TIE_OUT_W-1:0]  res_ties;
    logic [CAP_OUT_W-1:0]  res_cap;
    logic [COST_OUT_W-1:0] res_cost;

    // back: memories, pair walk and cost
    scdc_back #(
        .MAX_NODES (MAX_NODES),
        .DIST_BITS (DIST_BITS),
        .NODE_W    (NODE_W),
        .CMD_W     (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_min       (res_min),
        .o_ties      (res_ties),
        .o_cap       (res_cap),
        .o_cost      (res_cost)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_cost, res_cap, res_ties, res_min};

endmodule

>>> dv/tb_subset_min_pair_distance_cost.sv
`timescale 1ns / 100ps

module tb_subset_min_pair_distance_cost;
    import scdc_pkg::*;

    localparam int unsigned NODES          = 64;
    localparam int unsigned TIE_LO         = MIN_OUT_W;
    localparam int unsigned CAP_LO         = TIE_LO + TIE_OUT_W;
    localparam int unsigned COST_LO        = CAP_LO + CAP_OUT_W;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned HOLD_CYCLES    = 7000;
    localparam int unsigned CYCLE_LIMIT    = 4_000_000;
    localparam int unsigned SECTION_ITEMS  = 20;
    localparam int unsigned SECTION_EVALS  = 3;

    // op codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [MIN_OUT_W-1:0]         min_distance;
        logic [TIE_OUT_W-1:0]         tie_count;
        logic [CAP_OUT_W-1:0]         selected_capacity;
        logic signed [COST_OUT_W-1:0] cost;
    } t_eval_word;

    // mirror of the subset state and the evaluate results still owed
    class subset_cost_scoreboard;
        logic [VALUE_W-1:0]  distance_tab [NODES][NODES];
        logic [VALUE_W-1:0]  capacity_tab [NODES];
        bit                  selected [NODES];
        int unsigned         capacity_sum;
        logic [CFG_W-1:0]    required_capacity;
        logic [CFG_W-1:0]    capacity_weight;
        logic [CFG_W-1:0]    distance_weight;
        logic [NCOUNT_W-1:0] node_count;
        t_eval_word          pending_evals [$];
        int unsigned         failures;
        int unsigned         results_checked;
        longint unsigned     max_ties;

        function new();
            foreach (distance_tab[i, j]) distance_tab[i][j] = '0;
            foreach (capacity_tab[i]) capacity_tab[i] = '0;
            foreach (selected[i]) selected[i] = 1'b0;
            capacity_sum      = 0;
            required_capacity = REQ_RESET;
            capacity_weight   = CW_RESET;
            distance_weight   = DW_RESET;
            node_count        = NCOUNT_RESET;
            failures          = 0;
            results_checked   = 0;
            max_ties          = 0;
        endfunction

        function int unsigned nodes_in_use();
            return (node_count < NODES) ? node_count : NODES;
        endfunction

        function void apply_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_REQ:    required_capacity = data;
                CFG_CW:     capacity_weight = data;
                CFG_DW:     distance_weight = data;
                CFG_NCOUNT: node_count = data[NCOUNT_W-1:0];
                default:    ;
            endcase
        endfunction

        // walk all selected pairs: minimum, ties, then the weighted cost
        function t_eval_word evaluate_subset();
            t_eval_word      r;
            bit              found;
            int unsigned     i;
            int unsigned     j;
            longint unsigned min_d;
            longint unsigned ties;
            longint unsigned shortfall;
            longint          cost;
            found = 1'b0;
            min_d = 0;
            ties  = 0;
            for (i = 0; i < NODES; i++) begin
                if (!selected[i]) continue;
                for (j = i + 1; j < NODES; j++) begin
                    if (!selected[j]) continue;
                    if (!found || distance_tab[i][j] < min_d) begin
                        min_d = distance_tab[i][j];
                        ties  = 1;
                        found = 1'b1;
                    end else if (distance_tab[i][j] == min_d) begin
                        ties++;
                    end
                end
            end
            shortfall = (capacity_sum < required_capacity) ?
                        required_capacity - capacity_sum : 0;
            cost = longint'(distance_weight) * longint'(min_d)
                 - longint'(capacity_weight) * longint'(shortfall)
                 - longint'(ties);
            r.min_distance      = min_d[MIN_OUT_W-1:0];
            r.tie_count         = ties[TIE_OUT_W-1:0];
            r.selected_capacity = capacity_sum[CAP_OUT_W-1:0];
            r.cost              = cost[COST_OUT_W-1:0];
            if (ties > max_ties) max_ties = ties;
            return r;
        endfunction

        // update the mirror for one accepted input word
        function void apply_item(logic [OP_W-1:0] op, logic [NODE_IN_W-1:0] a,
                                 logic [NODE_IN_W-1:0] b, logic [VALUE_W-1:0] value);
            int unsigned n;
            n = nodes_in_use();
            case (op)
                OP_WDIST: begin
                    if (a < n && b < n) begin
                        distance_tab[a][b] = value;
                        distance_tab[b][a] = value;
                    end
                end
                OP_WCAP: begin
                    if (a < n) begin
                        if (selected[a]) capacity_sum = capacity_sum - capacity_tab[a] + value;
                        capacity_tab[a] = value;
                    end
                end
                OP_SEL: begin
                    if (a < n && !selected[a]) begin
                        selected[a] = 1'b1;
                        capacity_sum += capacity_tab[a];
                    end
                end
                OP_DESEL: begin
                    // out-of-range nodes can still leave the subset
                    if (selected[a]) begin
                        selected[a] = 1'b0;
                        capacity_sum -= capacity_tab[a];
                    end
                end
                OP_EVAL: pending_evals.insert(pending_evals.size(), evaluate_subset());
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint expected, longint actual);
            if (expected != actual) begin
                failures++;
                $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] w);
            t_eval_word e;
            if (pending_evals.size() == 0) begin
                failures++;
                $error("result word with no evaluate waiting");
                return;
            end
            e = pending_evals.pop_front();
            results_checked++;
            compare_field("min_distance", longint'(e.min_distance),
                          longint'(w[0 +: MIN_OUT_W]));
            compare_field("tie_count", longint'(e.tie_count),
                          longint'(w[TIE_LO +: TIE_OUT_W]));
            compare_field("selected_capacity", longint'(e.selected_capacity),
                          longint'(w[CAP_LO +: CAP_OUT_W]));
            compare_field("cost", longint'(e.cost),
                          longint'($signed(w[COST_LO +: COST_OUT_W])));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_cfg_ready;

    subset_cost_scoreboard sb;
    int unsigned           tx_idle_pct = 0;
    int unsigned           rx_idle_pct = 0;
    bit                    hold_req    = 1'b0;
    int unsigned           holds_done  = 0;
    int unsigned           items_sent  = 0;
    int unsigned           evals_sent  = 0;
    int unsigned           settings    = 1;
    int unsigned           cycle_count = 0;

    subset_min_pair_distance_cost u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // 12 ns clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("tb_subset_min_pair_distance_cost NOT OK");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // check every result word taken
    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready) sb.check_result(o_m_axis_tdata);
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0:       return $urandom_range(3);
            1:       return $urandom_range(15);
            2:       return $urandom_range(65535);
            default: return 16'hFFFF - $urandom_range(1);
        endcase
    endfunction

    // offer one input word, with a random gap ahead of it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_IN_W-1:0] a,
                             input logic [NODE_IN_W-1:0] b, input logic [VALUE_W-1:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD_W{1'b0}}, value, b, a};
        s_tuser  <= op;
        do @(posedge clk); while (!o_s_axis_tready);
        sb.apply_item(op, a, b, value);
        items_sent++;
        if (op == OP_EVAL) evals_sent++;
    endtask

    task automatic send_eval();
        send_item(OP_EVAL, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
    endtask

    task automatic clear_selection();
        int unsigned i;
        for (i = 0; i < NODES; i++) begin
            if (sb.selected[i]) send_item(OP_DESEL, i, $urandom_range(63), $urandom_range(65535));
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        sb.apply_register(idx, data);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] req, input logic [CFG_W-1:0] cw,
                              input logic [CFG_W-1:0] dw, input logic [NCOUNT_W-1:0] nc);
        cfg_write(CFG_REQ, req);
        cfg_write(CFG_CW, cw);
        cfg_write(CFG_DW, dw);
        cfg_write(CFG_NCOUNT, {{(CFG_W-NCOUNT_W){1'b0}}, nc});
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // wait for every owed result, then let trailing writes settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_evals.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one random sequence, mostly well formed: load, select, evaluate
    task automatic random_sequence();
        int unsigned       n;
        int unsigned       kind;
        int unsigned       k;
        int unsigned       i;
        int unsigned       j;
        int unsigned       node;
        logic [NODES-1:0]  chosen;
        int unsigned       picks [$];
        n    = sb.nodes_in_use();
        kind = $urandom_range(99);
        if (kind < 40) begin
            // fresh small subset with its own distances
            if ($urandom_range(3) != 0) clear_selection();
            k = $urandom_range(2, (n < 4) ? n : 4);
            chosen = '0;
            while (picks.size() < k) begin
                node = $urandom_range(n - 1);
                if (!chosen[node]) begin
                    chosen[node] = 1'b1;
                    picks.insert(picks.size(), node);
                end
            end
            for (i = 0; i < k; i++) begin
                for (j = i + 1; j < k; j++) begin
                    if ($urandom_range(1)) send_item(OP_WDIST, picks[i], picks[j], rand_value());
                    else send_item(OP_WDIST, picks[j], picks[i], rand_value());
                end
            end
            for (i = 0; i < k; i++) begin
                if ($urandom_range(1))
                    send_item(OP_WCAP, picks[i], $urandom_range(63), rand_value());
            end
            for (i = 0; i < k; i++) send_item(OP_SEL, picks[i], $urandom_range(63), 0);
            send_eval();
        end else if (kind < 70) begin
            // small edits to the current subset
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(2))
                    0:       send_item(OP_SEL, $urandom_range(n - 1), $urandom_range(63),
                                       $urandom_range(65535));
                    1:       send_item(OP_DESEL, $urandom_range(NODES - 1), $urandom_range(63),
                                       $urandom_range(65535));
                    default: send_item(OP_WCAP, $urandom_range(n - 1), $urandom_range(63),
                                       rand_value());
                endcase
            end
            send_eval();
        end else if (kind < 90) begin
            // noise over every code and node
            repeat ($urandom_range(1, 4)) begin
                send_item($urandom_range(7), $urandom_range(63), $urandom_range(63),
                          $urandom_range(65535));
            end
        end else begin
            clear_selection();
            if ($urandom_range(1)) send_eval();
        end
    endtask

    // one register setting with its random stimulus
    task automatic run_section(input logic [CFG_W-1:0] req, input logic [CFG_W-1:0] cw,
                               input logic [CFG_W-1:0] dw, input logic [NCOUNT_W-1:0] nc,
                               input bit fill, input bit squeeze);
        int unsigned items_start;
        int unsigned evals_start;
        int unsigned i;
        write_regs(req, cw, dw, nc);
        items_start = items_sent;
        evals_start = evals_sent;
        if (squeeze) begin
            // receiver holds off while evaluates pile up behind it
            hold_req = 1'b1;
            for (i = 0; i < 10; i++) begin
                if (i % 3 == 2)
                    send_item(OP_WCAP, $urandom_range(nc - 1), $urandom_range(63), rand_value());
                else
                    send_eval();
            end
        end
        if (fill) begin
            // every node in use selected at once
            for (i = 0; i < sb.nodes_in_use(); i++) begin
                if (!sb.selected[i]) send_item(OP_SEL, i, $urandom_range(63), 0);
            end
            send_eval();
        end
        while (items_sent - items_start < SECTION_ITEMS ||
               evals_sent - evals_start < SECTION_EVALS) begin
            random_sequence();
        end
        drain();
    endtask

    initial begin
        sb = new();
        tx_idle_pct = 6;
        rx_idle_pct = 78;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty subset, single node, first pair, edge values
        send_eval();
        send_item(OP_WCAP, 0, 0, 16'hFFFF);
        send_item(OP_WCAP, 63, 63, 16'hFFFF);
        send_item(OP_WDIST, 0, 63, 16'hFFFF);
        send_item(OP_WDIST, 5, 5, 16'h5A5A);
        send_item(OP_SEL, 0, 0, 0);
        send_eval();
        // select twice is a no-op
        send_item(OP_SEL, 0, 0, 0);
        send_item(OP_SEL, 63, 0, 0);
        send_eval();
        // capacity change on a selected node moves the sum
        send_item(OP_WCAP, 63, 0, 16'd1);
        send_item(OP_DESEL, 5, 0, 0);
        send_item(OP_SPARE_LO, 63, 63, 16'hFFFF);
        send_item(OP_SPARE_HI, 63, 63, 16'hFFFF);
        send_item(OP_SEL, 5, 0, 0);
        send_eval();
        send_item(OP_DESEL, 0, 0, 0);
        send_item(OP_SEL, 40, 0, 0);
        send_item(OP_SEL, 50, 0, 0);
        send_eval();
        drain();

        // directed: node count lowered under selected nodes, all weights at max
        write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd4);
        send_eval();
        send_item(OP_WDIST, 1, 10, 16'h1234);
        send_item(OP_WCAP, 10, 0, 16'h4321);
        send_item(OP_SEL, 10, 0, 0);
        send_item(OP_DESEL, 50, 0, 0);
        send_eval();
        drain();

        // random sections
        run_section($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    7'd5, 1'b0, 1'b0);
        run_section(16'd0, 16'd0, 16'd0, 7'd64, 1'b1, 1'b0);
        tx_idle_pct = 78;
        rx_idle_pct = 6;
        run_section(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd2, 1'b1, 1'b0);
        run_section($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    7'd33, 1'b0, 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_section($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    7'd8, 1'b1, 1'b1);
        run_section($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    7'd63, 1'b0, 1'b0);

        $display("sent %0d words, checked %0d evaluate results across %0d register settings",
                 items_sent, sb.results_checked, settings);
        $display("largest tie count %0d, long receiver hold-offs %0d",
                 sb.max_ties, holds_done);
        if (sb.failures == 0) begin
            $display("tb_subset_min_pair_distance_cost OK");
        end else begin
            $display("tb_subset_min_pair_distance_cost NOT OK");
        end
        $finish;
    end

endmodule
